[hdl/stm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Station table package
// Shared types and codes for the station table controller and datapath.
// ----------------------------------------------------------------------------
package stm_pkg;

  localparam int ADDR_W = 48;

  typedef enum logic [2:0] {
    FN_PREPARE  = 3'd0,
    FN_UPLOAD   = 3'd1,
    FN_CLEAR    = 3'd2,
    FN_MARK     = 3'd3,
    FN_RESTORE  = 3'd4,
    FN_BCAST    = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BUSY    = 3'd1,
    ST_PRESENT = 3'd2,
    ST_FULL    = 3'd3,
    ST_BADIDX  = 3'd4,
    ST_FAIL    = 3'd5
  } status_t;

  localparam logic [1:0] REG_AP0 = 2'd0;
  localparam logic [1:0] REG_BC0 = 2'd1;
  localparam logic [1:0] REG_AP1 = 2'd2;
  localparam logic [1:0] REG_BC1 = 2'd3;

  localparam int FL_KNOWN    = 0;
  localparam int FL_UPLOADED = 1;
  localparam int FL_BUSY     = 2;
  localparam int FL_BCAST    = 3;

  typedef struct packed {
    logic [2:0]  func;
    logic [47:0] mac_address;
    logic        is_access_point;
    logic        context_id;
    logic        all_contexts;
    logic [7:0]  slot_index;
    logic        upload_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0] result_slot;
    logic       slot_valid;
    logic [2:0] status;
    logic [4:0] affected_count;
    logic [7:0] station_total;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_DECIDE,
    S_APPLY,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic init_step;
    logic scan_step;
    logic decide;
    logic apply;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic scan_done;
  } stat_t;

endpackage

[hdl/stm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Station table controller
// Sequences clear pass, slot scan, decision, write-back and result hand-off.
// ----------------------------------------------------------------------------
module stm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  stm_pkg::stat_t stat,
  output stm_pkg::cmd_t  cmd
);
  import stm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (stat.init_done) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (stat.scan_done) state_next = S_DECIDE;
      S_DECIDE: state_next = S_APPLY;
      S_APPLY: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_CLEAR: cmd.init_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_DECIDE: cmd.decide = 1'b1;
      S_APPLY: cmd.apply = 1'b1;
      S_OUT: begin
        out_valid = 1'b1;
        cmd.publish = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[hdl/stm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Station table datapath
// Entry storage, slot scan, operation decode and result register.
// ----------------------------------------------------------------------------
module stm_dp #(
  parameter int SLOT_COUNT   = 16,
  parameter int SEARCH_START = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  stm_pkg::in_item_t   in_item,
  input  stm_pkg::cmd_t       cmd,
  output stm_pkg::stat_t      stat,
  output stm_pkg::out_item_t  out_item
);
  import stm_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int SS = (SEARCH_START < SLOT_COUNT) ? SEARCH_START : SLOT_COUNT - 1;
  localparam bit SCAN_ON = (SEARCH_START < SLOT_COUNT);
  localparam logic [CW-1:0] LAST = CW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] START = CW'(SS);
  localparam logic [8:0] SLOT_LIM = 9'(SLOT_COUNT);

  logic [ADDR_W-1:0] entry_address [SLOT_COUNT];
  logic [3:0]        entry_flags   [SLOT_COUNT];
  logic              entry_context [SLOT_COUNT];
  logic [7:0]        added_total;
  logic [3:0]        ap_slot0, ap_slot1, bc_slot0, bc_slot1;

  in_item_t          op;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     match_slot, free_slot;
  logic              match_hit, free_hit;
  logic [CW-1:0]     affected;
  logic [CW-1:0]     sel;
  logic              sel_ok;
  logic [2:0]        res_status;
  logic [4:0]        res_count;
  logic              do_claim;
  logic [ADDR_W-1:0] op_addr;
  logic [3:0]        cfg_slot;
  logic [IW-1:0]     ci, si;
  logic              in_scope, cand;

  assign ci = cnt[IW-1:0];
  assign si = sel[IW-1:0];
  assign op_addr = (op.func == FN_BCAST) ? {ADDR_W{1'b1}} : op.mac_address;

  assign stat.init_done  = (cnt == LAST);
  assign stat.scan_done  = (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      ap_slot0 <= 4'd0;
      bc_slot0 <= 4'd15;
      ap_slot1 <= 4'd1;
      bc_slot1 <= 4'd14;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AP0: ap_slot0 <= cfg_data;
        REG_BC0: bc_slot0 <= cfg_data;
        REG_AP1: ap_slot1 <= cfg_data;
        REG_BC1: bc_slot1 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_scope = 1'b0;
    cand = 1'b0;
    case (op.func)
      FN_CLEAR: begin
        in_scope = op.all_contexts || (entry_context[ci] == op.context_id);
        cand = in_scope && entry_flags[ci][FL_UPLOADED];
      end
      FN_MARK: begin
        in_scope = (entry_context[ci] == op.context_id);
        cand = in_scope && entry_flags[ci][FL_KNOWN] && !entry_flags[ci][FL_UPLOADED];
      end
      default: ;
    endcase
  end

  always_comb begin
    if (op.func == FN_BCAST || (op.func == FN_PREPARE && !op.is_access_point
        && op.mac_address == {ADDR_W{1'b1}})) begin
      cfg_slot = op.context_id ? bc_slot1 : bc_slot0;
    end else begin
      cfg_slot = op.context_id ? ap_slot1 : ap_slot0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      added_total <= '0;
    end else if (cmd.init_step) begin
      entry_address[ci] <= '0;
      entry_flags[ci] <= '0;
      entry_context[ci] <= 1'b0;
      cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
    end else if (cmd.load) begin
      op <= in_item;
      cnt <= '0;
      match_hit <= 1'b0;
      free_hit <= 1'b0;
      affected <= '0;
    end else if (cmd.scan_step) begin
      if (SCAN_ON && cnt >= START) begin
        if (!match_hit && entry_address[ci] == op_addr) begin
          match_hit <= 1'b1;
          match_slot <= cnt;
        end
        if (!free_hit && entry_flags[ci] == 4'd0) begin
          free_hit <= 1'b1;
          free_slot <= cnt;
        end
      end
      if (cand) begin
        affected <= affected + 1'b1;
        if (op.func == FN_CLEAR) entry_flags[ci][FL_UPLOADED] <= 1'b0;
        else entry_flags[ci][FL_BUSY] <= 1'b1;
      end
      cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
    end else if (cmd.decide) begin
      res_status <= ST_OK;
      res_count <= '0;
      do_claim <= 1'b0;
      sel_ok <= 1'b0;
      sel <= '0;
      case (op.func)
        FN_PREPARE, FN_BCAST: begin
          if (op.func == FN_BCAST || op.is_access_point
              || op.mac_address == {ADDR_W{1'b1}}) begin
            sel <= CW'(cfg_slot);
            sel_ok <= ({5'd0, cfg_slot} < SLOT_LIM);
          end else if (match_hit) begin
            sel <= match_slot;
            sel_ok <= 1'b1;
          end else begin
            sel <= free_slot;
            sel_ok <= free_hit;
          end
        end
        FN_UPLOAD, FN_RESTORE: begin
          sel <= CW'(op.slot_index[IW-1:0]);
          sel_ok <= ({1'b0, op.slot_index} < SLOT_LIM);
        end
        FN_CLEAR, FN_MARK: res_count <= 5'(affected);
        default: ;
      endcase
    end else if (cmd.apply) begin
      case (op.func)
        FN_PREPARE, FN_BCAST: begin
          if (!sel_ok) begin
            res_status <= ST_FULL;
          end else if (entry_flags[si][FL_BUSY]) begin
            res_status <= ST_BUSY;
            if (op.func == FN_BCAST) begin
              entry_flags[si] <= entry_flags[si] | 4'b1001;
            end
          end else if (entry_flags[si][FL_KNOWN] && entry_flags[si][FL_UPLOADED]
                       && entry_address[si] == op_addr) begin
            res_status <= ST_PRESENT;
            if (op.func == FN_BCAST) begin
              entry_flags[si] <= entry_flags[si] | 4'b1001;
            end
          end else begin
            entry_flags[si] <= (op.func == FN_BCAST) ? 4'b1001 : 4'b0001;
            entry_address[si] <= op_addr;
            entry_context[si] <= op.context_id;
            if (added_total != 8'hFF) added_total <= added_total + 8'd1;
            res_count <= 5'd1;
          end
        end
        FN_UPLOAD: begin
          if (!sel_ok) res_status <= ST_BADIDX;
          else if (!op.upload_ok) res_status <= ST_FAIL;
          else if (entry_flags[si][FL_UPLOADED]) res_status <= ST_PRESENT;
          else entry_flags[si][FL_UPLOADED] <= 1'b1;
        end
        FN_RESTORE: begin
          if (!sel_ok) begin
            res_status <= ST_BADIDX;
          end else if (entry_flags[si][FL_BUSY]) begin
            res_count <= 5'd1;
            if (op.upload_ok) begin
              if (entry_flags[si][FL_UPLOADED]) res_status <= ST_PRESENT;
              entry_flags[si] <= (entry_flags[si] | 4'b0010) & 4'b1011;
            end else begin
              res_status <= ST_FAIL;
              entry_flags[si] <= entry_flags[si] & 4'b1010;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_item.result_slot    = sel_ok ? 4'(sel) : 4'd0;
    out_item.slot_valid     = sel_ok;
    out_item.status         = res_status;
    out_item.affected_count = res_count;
    out_item.station_total  = added_total;
  end

endmodule

[hdl/station_table_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Station table manager
// Slot table for wireless stations: prepare, broadcast, upload tracking, clear, mark, restore.
//
//   channel | signals                          | transfer when
//   in      | in_valid, in_ready, in_data      | in_valid && in_ready
//   out     | out_valid, out_ready, out_data   | out_valid && out_ready
//   cfg     | cfg_we, cfg_index, cfg_data      | cfg_we
//
// Each item runs through the accepting idle state, one pass over the entry
// store, then decide, write-back and result states; the result is offered
// after the scan, decide and write-back states that follow the transfer.
// After reset a clearing pass over the entry store runs before in_ready.
// A stalled result holds the block; no new item is taken until it leaves.
// ----------------------------------------------------------------------------
module station_table_manager #(
  parameter int SLOT_COUNT   = 16,
  parameter int SEARCH_START = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  stm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stm_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data
);
  import stm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  stm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  stm_dp #(.SLOT_COUNT(SLOT_COUNT), .SEARCH_START(SEARCH_START)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_item(in_data), .cmd, .stat, .out_item(out_data)
  );

  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("in_ready and out_valid together");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.slot_valid |-> out_data.result_slot == 4'd0)
    else $error("result slot set without a valid slot");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
